// File: hw/rtl/benc_pkg.sv
package benc_pkg;

    // configuration register codes
    localparam int unsigned MODE_W     = 2;
    localparam logic [MODE_W-1:0] MODE_B16   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_B32   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_B64   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_B64;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned HELD_W   = 32;
    localparam int unsigned ACC_W    = 40;
    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned NDATA_W  = 4;
    localparam int unsigned KIDX_W   = 3;
    localparam int unsigned CNT_W    = 3;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 7'h41;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 7'h61;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_TWO   = 7'h32;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_SLASH = 7'h2F;
    localparam logic [CHAR_W-1:0] CH_MIN   = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_MAX   = 7'h7A;

    // group queue sizing
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        FMT_B16,
        FMT_B32,
        FMT_B64
    } t_fmt;

    // one finished group: bits top-aligned, format and count of data chars
    typedef struct packed {
        logic [ACC_W-1:0]   sh;
        t_fmt               fmt;
        logic [NDATA_W-1:0] ndata;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [CHAR_W-1:0] enc16(input logic [3:0] v);
        logic [CHAR_W-1:0] w;
        w = {3'b000, v};
        if (v < 4'd10) begin
            enc16 = CH_ZERO + w;
        end else begin
            enc16 = CH_UP_A + w - 7'd10;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] enc32(input logic [4:0] v);
        logic [CHAR_W-1:0] w;
        w = {2'b00, v};
        if (v < 5'd26) begin
            enc32 = CH_UP_A + w;
        end else begin
            enc32 = CH_TWO + w - 7'd26;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] enc64(input logic [5:0] v);
        logic [CHAR_W-1:0] w;
        w = {1'b0, v};
        if (v < 6'd26) begin
            enc64 = CH_UP_A + w;
        end else if (v < 6'd52) begin
            enc64 = CH_LO_A + w - 7'd26;
        end else if (v < 6'd62) begin
            enc64 = CH_ZERO + w - 7'd52;
        end else if (v == 6'd62) begin
            enc64 = CH_PLUS;
        end else begin
            enc64 = CH_SLASH;
        end
    endfunction

endpackage

// File: hw/rtl/benc_if.sv
// input byte channel
interface benc_in_if;
    logic                         valid;
    logic                         ready;
    logic [benc_pkg::BYTE_W-1:0]  in_byte;
    logic                         end_of_message;

    modport source (output valid, output in_byte, output end_of_message, input ready);
    modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

// output character channel
interface benc_out_if;
    logic                         valid;
    logic                         ready;
    logic [benc_pkg::CHAR_W-1:0]  out_char;
    logic                         last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

// File: hw/rtl/base16_32_64_stream_encoder_top.sv
// throughput: one byte beat per cycle in while the queue has room, one character beat per
//   cycle out while the sink is ready; the output side sets the sustained rate at two
//   characters per byte in base16, 1.6 in base32 and 1.33 in base64
// a two-entry group queue lets the byte side run on while the character side drains
// reset: synchronous, active low; mode returns to base64, open group, queue and output clear
module base16_32_64_stream_encoder_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    benc_in_if.sink                      i_in,
    benc_out_if.source                   o_out,
    input  logic                         i_cfg_we,
    input  logic [benc_pkg::MODE_W-1:0]  i_cfg_data
);

    // mode register, a write also drops the open partial group in the front
    logic [benc_pkg::MODE_W-1:0] r_mode;

    // front to queue
    logic              q_push;
    benc_pkg::t_group  q_in;

    // queue to back
    logic              q_pop;
    benc_pkg::t_group  q_head;
    benc_pkg::t_qstat  q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= benc_pkg::MODE_RESET;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    // front: collects bytes, closes groups on fill or end of message
    benc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_mode  (r_mode),
        .i_cfg_we(i_cfg_we),
        .i_qstat (q_stat),
        .o_push  (q_push),
        .o_group (q_in)
    );

    // short queue of closed groups
    benc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_group (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_qstat (q_stat)
    );

    // back: one character per beat from a shifting group word, pads at the tail
    benc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_qstat (q_stat),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("group pushed into full queue");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("group popped from empty queue");

    // every character beat is a printable alphabet code or pad
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.out_char >= benc_pkg::CH_MIN) &&
                        (o_out.out_char <= benc_pkg::CH_MAX))
        else $error("character out of alphabet range");

    // output is empty right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

endmodule

// File: hw/rtl/benc_front.sv
module benc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    benc_in_if.sink                       i_in,
    input  logic [benc_pkg::MODE_W-1:0]   i_mode,
    input  logic                          i_cfg_we,
    input  benc_pkg::t_qstat              i_qstat,
    output logic                          o_push,
    output benc_pkg::t_group              o_group
);

    logic [benc_pkg::HELD_W-1:0] r_held, n_held;
    logic [benc_pkg::CNT_W-1:0]  r_count, n_count;

    benc_pkg::t_fmt              fmt;
    logic [benc_pkg::CNT_W-1:0]  group;
    logic [benc_pkg::CNT_W-1:0]  count;
    logic [benc_pkg::CNT_W-1:0]  gap;
    logic [benc_pkg::ACC_W-1:0]  acc;
    logic [benc_pkg::ACC_W-1:0]  aligned;
    logic                        accept;
    logic                        done;

    always_comb begin
        case (i_mode)
            benc_pkg::MODE_B16: begin
                fmt   = benc_pkg::FMT_B16;
                group = 3'd1;
            end
            benc_pkg::MODE_B32: begin
                fmt   = benc_pkg::FMT_B32;
                group = 3'd5;
            end
            default: begin
                fmt   = benc_pkg::FMT_B64;
                group = 3'd3;
            end
        endcase
    end

    assign i_in.ready = !i_qstat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign count      = r_count + 3'd1;
    assign done       = (count >= group) || i_in.end_of_message;
    assign gap        = group - count;
    assign acc        = {r_held, i_in.in_byte};

    // zero-fill the missing bytes of a short group
    always_comb begin
        case (gap)
            3'd0:    aligned = acc;
            3'd1:    aligned = {acc[31:0], 8'h00};
            3'd2:    aligned = {acc[23:0], 16'h0000};
            3'd3:    aligned = {acc[15:0], 24'h000000};
            default: aligned = {acc[7:0], 32'h00000000};
        endcase
    end

    always_comb begin
        o_group.fmt = fmt;
        case (fmt)
            benc_pkg::FMT_B16: begin
                o_group.sh    = {i_in.in_byte, 32'h00000000};
                o_group.ndata = 4'd2;
            end
            benc_pkg::FMT_B32: begin
                o_group.sh = aligned;
                case (count)
                    3'd1:    o_group.ndata = 4'd2;
                    3'd2:    o_group.ndata = 4'd4;
                    3'd3:    o_group.ndata = 4'd5;
                    3'd4:    o_group.ndata = 4'd7;
                    default: o_group.ndata = 4'd8;
                endcase
            end
            default: begin
                o_group.sh = {aligned[23:0], 16'h0000};
                case (count)
                    3'd1:    o_group.ndata = 4'd2;
                    3'd2:    o_group.ndata = 4'd3;
                    default: o_group.ndata = 4'd4;
                endcase
            end
        endcase
    end

    assign o_push = accept && done;

    always_comb begin
        n_held  = r_held;
        n_count = r_count;
        if (i_cfg_we) begin
            n_held  = '0;
            n_count = '0;
        end else if (accept) begin
            if (done) begin
                n_held  = '0;
                n_count = '0;
            end else begin
                n_held  = {r_held[23:0], i_in.in_byte};
                n_count = count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_count <= '0;
        end else begin
            r_held  <= n_held;
            r_count <= n_count;
        end
    end

endmodule

// File: hw/rtl/benc_queue.sv
module benc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  benc_pkg::t_group  i_group,
    input  logic              i_pop,
    output benc_pkg::t_group  o_head,
    output benc_pkg::t_qstat  o_qstat
);

    benc_pkg::t_group                   r_mem [benc_pkg::Q_DEPTH];
    logic [benc_pkg::Q_PTR_W-1:0]       r_wp, n_wp;
    logic [benc_pkg::Q_PTR_W-1:0]       r_rp, n_rp;
    logic [benc_pkg::Q_CNT_W-1:0]       r_cnt, n_cnt;

    function automatic logic [benc_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [benc_pkg::Q_PTR_W-1:0] p
    );
        if (p == benc_pkg::Q_PTR_W'(benc_pkg::Q_DEPTH - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = p + 1'b1;
        end
    endfunction

    assign o_head        = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == benc_pkg::Q_CNT_W'(benc_pkg::Q_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    always_comb begin
        n_wp  = i_push ? ptr_inc(r_wp) : r_wp;
        n_rp  = i_pop ? ptr_inc(r_rp) : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_group;
        end
    end

endmodule

// File: hw/rtl/benc_back.sv
module benc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  benc_pkg::t_group  i_head,
    input  benc_pkg::t_qstat  i_qstat,
    output logic              o_pop,
    benc_out_if.source        o_out
);

    logic                                r_busy, n_busy;
    logic [benc_pkg::ACC_W-1:0]          r_sh, n_sh;
    benc_pkg::t_fmt                      r_fmt, n_fmt;
    logic [benc_pkg::NDATA_W-1:0]        r_ndata, n_ndata;
    logic [benc_pkg::KIDX_W-1:0]         r_k, n_k;
    logic                                r_out_valid, n_out_valid;
    logic [benc_pkg::CHAR_W-1:0]         r_out_char, n_out_char;
    logic                                r_out_last, n_out_last;

    logic                                load;
    logic                                is_last;
    logic [benc_pkg::KIDX_W-1:0]         last_k;
    logic [benc_pkg::CHAR_W-1:0]         data_char;
    logic [benc_pkg::ACC_W-1:0]          sh_next;

    always_comb begin
        case (r_fmt)
            benc_pkg::FMT_B16: begin
                last_k    = 3'd1;
                data_char = benc_pkg::enc16(r_sh[39:36]);
                sh_next   = {r_sh[35:0], 4'h0};
            end
            benc_pkg::FMT_B32: begin
                last_k    = 3'd7;
                data_char = benc_pkg::enc32(r_sh[39:35]);
                sh_next   = {r_sh[34:0], 5'h00};
            end
            default: begin
                last_k    = 3'd3;
                data_char = benc_pkg::enc64(r_sh[39:34]);
                sh_next   = {r_sh[33:0], 6'h00};
            end
        endcase
    end

    assign is_last = (r_k == last_k);
    assign load    = r_busy && (!r_out_valid || o_out.ready);
    assign o_pop   = !i_qstat.empty && (!r_busy || (load && is_last));

    always_comb begin
        n_busy  = r_busy;
        n_sh    = r_sh;
        n_fmt   = r_fmt;
        n_ndata = r_ndata;
        n_k     = r_k;
        if (o_pop) begin
            n_busy  = 1'b1;
            n_sh    = i_head.sh;
            n_fmt   = i_head.fmt;
            n_ndata = i_head.ndata;
            n_k     = '0;
        end else if (load) begin
            n_sh = sh_next;
            n_k  = r_k + 1'b1;
            if (is_last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        if (load) begin
            n_out_valid = 1'b1;
            n_out_char  = ({1'b0, r_k} >= r_ndata) ? benc_pkg::PAD_CHAR : data_char;
            n_out_last  = is_last;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_char    = r_out_char;
    assign o_out.last_of_run = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh       <= n_sh;
        r_fmt      <= n_fmt;
        r_ndata    <= n_ndata;
        r_k        <= n_k;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

endmodule
